// ===== rtl/core/dtc_pkg.sv =====
package dtc_pkg;

  // fixed geometry of the block
  localparam int MAX_DIMS     = 4;
  localparam int COORD_BITS   = 16;
  localparam int VALUE_BITS   = 32;
  localparam int NDIM_BITS    = 3;
  localparam int EXT_BITS     = COORD_BITS + 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = EXT_BITS;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic [EXT_BITS-1:0]          ext_t;
  typedef logic [NDIM_BITS-1:0]         ndim_t;

  // largest extent a coordinate can count through
  localparam ext_t  EXT_MAX  = ext_t'(1) << COORD_BITS;
  localparam ext_t  EXT_ONE  = ext_t'(1);
  localparam ndim_t NDIM_MAX = ndim_t'(MAX_DIMS);
  localparam ndim_t NDIM_ONE = ndim_t'(1);

  // configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_DIMS  = 3'd0,
    REG_DIM0_SIZE = 3'd1,
    REG_DIM1_SIZE = 3'd2,
    REG_DIM2_SIZE = 3'd3,
    REG_DIM3_SIZE = 3'd4
  } cfg_reg_t;

  // cleaned-up tensor shape handed to the counter
  typedef struct packed {
    ndim_t                    active_dims;
    ext_t [MAX_DIMS-1:0]      extent;
  } geom_t;

  // pipeline status seen by the top level
  typedef struct packed {
    logic s1_valid;
    logic s1_go;
    logic s1_nonzero;
  } pipe_stat_t;

endpackage

// ===== rtl/core/dtc_cfg.sv =====
module dtc_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dtc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [dtc_pkg::CFG_DAT_BITS-1:0]      cfg_data,
  output dtc_pkg::geom_t                        geom
);
  import dtc_pkg::*;

  ndim_t               num_dims_r, num_dims_nxt;
  ext_t [MAX_DIMS-1:0] size_r, size_nxt;
  logic                wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  // register write decode, unknown indexes are dropped
  always_comb begin
    num_dims_nxt = num_dims_r;
    size_nxt     = size_r;
    if (wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_DIMS:  num_dims_nxt = cfg_data[NDIM_BITS-1:0];
        REG_DIM0_SIZE: size_nxt[0]  = cfg_data[EXT_BITS-1:0];
        REG_DIM1_SIZE: size_nxt[1]  = cfg_data[EXT_BITS-1:0];
        REG_DIM2_SIZE: size_nxt[2]  = cfg_data[EXT_BITS-1:0];
        REG_DIM3_SIZE: size_nxt[3]  = cfg_data[EXT_BITS-1:0];
        default:       num_dims_nxt = num_dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= NDIM_ONE;
      for (int i = 0; i < MAX_DIMS; i++) size_r[i] <= EXT_ONE;
    end else begin
      num_dims_r <= num_dims_nxt;
      size_r     <= size_nxt;
    end
  end

  // clamp dimension count to 1..MAX_DIMS and each extent to 1..2^COORD_BITS
  always_comb begin
    if (num_dims_r == '0)
      geom.active_dims = NDIM_ONE;
    else if (num_dims_r > NDIM_MAX)
      geom.active_dims = NDIM_MAX;
    else
      geom.active_dims = num_dims_r;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (size_r[i] == '0)
        geom.extent[i] = EXT_ONE;
      else if (size_r[i] > EXT_MAX)
        geom.extent[i] = EXT_MAX;
      else
        geom.extent[i] = size_r[i];
    end
  end

endmodule

// ===== rtl/core/dtc_odometer.sv =====
module dtc_odometer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  dtc_pkg::geom_t                        geom,
  output dtc_pkg::coord_t [dtc_pkg::MAX_DIMS-1:0] coord
);
  import dtc_pkg::*;

  coord_t [MAX_DIMS-1:0] coord_r, coord_nxt;
  logic   [MAX_DIMS-1:0] used;
  logic   [MAX_DIMS-1:0] wrap;
  logic   [MAX_DIMS:0]   carry;
  ext_t   [MAX_DIMS-1:0] inc;

  // per-dimension increment and wrap detect
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      used[d] = (ndim_t'(d) < geom.active_dims);
      inc[d]  = {1'b0, coord_r[d]} + EXT_ONE;
      wrap[d] = (inc[d] >= geom.extent[d]);
    end
  end

  // carry ripples from the last dimension toward dimension 0,
  // unused dimensions pass it through untouched
  always_comb begin
    carry[MAX_DIMS] = 1'b1;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      carry[d] = carry[d+1] & (~used[d] | wrap[d]);
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (step && used[d] && carry[d+1])
        coord_nxt[d] = wrap[d] ? '0 : inc[d][COORD_BITS-1:0];
      else
        coord_nxt[d] = coord_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else begin
      coord_r <= coord_nxt;
    end
  end

  // report only the dimensions in use
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      coord[d] = used[d] ? coord_r[d] : '0;
    end
  end

endmodule

// ===== rtl/core/dtc_pipe.sv =====
module dtc_pipe (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  dtc_pkg::value_t                         in_value,
  input  dtc_pkg::coord_t [dtc_pkg::MAX_DIMS-1:0] in_coord,
  output logic                                    accept,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output dtc_pkg::value_t                         out_value,
  output dtc_pkg::coord_t [dtc_pkg::MAX_DIMS-1:0] out_coord,
  output dtc_pkg::pipe_stat_t                     stat
);
  import dtc_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  value_t                s1_value_r;
  coord_t [MAX_DIMS-1:0] s1_coord_r;
  logic                  out_valid_r, out_valid_nxt;
  value_t                out_value_r;
  coord_t [MAX_DIMS-1:0] out_coord_r;
  logic                  s1_nonzero;
  logic                  s1_go;
  logic                  out_free;
  logic                  load;

  // stage 1 drains when the word is zero or the result slot frees up
  assign s1_nonzero = |s1_value_r;
  assign out_free   = ~out_valid_r | out_ready;
  assign s1_go      = s1_valid_r & (~s1_nonzero | out_free);
  assign in_ready   = ~s1_valid_r | s1_go;
  assign accept     = in_valid & in_ready;
  assign load       = s1_go & s1_nonzero;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)
      s1_valid_nxt = 1'b1;
    else if (s1_go)
      s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, captured with the coordinate of its own element
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value;
      s1_coord_r <= in_coord;
    end
    if (load) begin
      out_value_r <= s1_value_r;
      out_coord_r <= s1_coord_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_coord = out_coord_r;
  assign stat      = '{s1_valid: s1_valid_r, s1_go: s1_go, s1_nonzero: s1_nonzero};

endmodule

// ===== rtl/core/dense_to_coo_sparse_encoder_core.sv =====
// dense to coo sparse encoder, row-major odometer over up to four dimensions
// an accepted nonzero element passes through the stage 1 register, then the result register
// throughput: one element per cycle, result slot stalls apply back pressure
// the odometer advances by one element per accepted word in the same cycle
// reset (rst_n low, synchronous): counter to all zeros, num_dims and sizes to 1,
// pipeline emptied
module dense_to_coo_sparse_encoder_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  dtc_pkg::value_t                       in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output dtc_pkg::value_t                       out_value_out,
  output dtc_pkg::coord_t                       out_coord_0,
  output dtc_pkg::coord_t                       out_coord_1,
  output dtc_pkg::coord_t                       out_coord_2,
  output dtc_pkg::coord_t                       out_coord_3,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dtc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [dtc_pkg::CFG_DAT_BITS-1:0]      cfg_data
);
  import dtc_pkg::*;

  geom_t                 geom;
  coord_t [MAX_DIMS-1:0] cur_coord;
  coord_t [MAX_DIMS-1:0] res_coord;
  logic                  accept;
  pipe_stat_t            stat;

  // configuration registers
  dtc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // coordinate counter
  dtc_odometer u_odometer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .geom  (geom),
    .coord (cur_coord)
  );

  // input stage and result register
  dtc_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .in_coord  (cur_coord),
    .accept    (accept),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value_out),
    .out_coord (res_coord),
    .stat      (stat)
  );

  assign out_coord_0 = res_coord[0];
  assign out_coord_1 = res_coord[1];
  assign out_coord_2 = res_coord[2];
  assign out_coord_3 = res_coord[3];

  // zero elements never reach the result port
  a_no_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_out != '0))
    else $error("zero element emitted");

  // a stalled stage 1 word is kept
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (stat.s1_valid && !stat.s1_go) |=> stat.s1_valid)
    else $error("stage 1 word lost while stalled");

  // a new result only comes from a nonzero stage 1 word
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stat.s1_go && stat.s1_nonzero))
    else $error("result word without a nonzero source");

endmodule

// ===== dv/dense_to_coo_sparse_encoder_core_tb.sv =====
`timescale 1ns / 100ps

module dense_to_coo_sparse_encoder_core_tb;
  import dtc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_MAX_WORDS = 96;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST = 3'd7;

  // one expected coo entry
  typedef struct packed {
    value_t              value;
    coord_t [MAX_DIMS-1:0] coord;
  } coo_entry_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  value_t in_value;
  logic out_valid;
  logic out_ready;
  value_t out_value_out;
  coord_t out_coord_0;
  coord_t out_coord_1;
  coord_t out_coord_2;
  coord_t out_coord_3;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DAT_BITS-1:0] cfg_data;

  // shadow of the shape registers and the odometer
  ndim_t shape_ndims;
  ext_t shape_ext [MAX_DIMS];
  coord_t odo_coord [MAX_DIMS];

  coo_entry_t pending_coo [$];
  coo_entry_t want;
  coord_t seen_coord [MAX_DIMS];
  int errors = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  dense_to_coo_sparse_encoder_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_out(out_value_out),
    .out_coord_0  (out_coord_0),
    .out_coord_1  (out_coord_1),
    .out_coord_2  (out_coord_2),
    .out_coord_3  (out_coord_3),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // dimension count after clamping to 1..MAX_DIMS
  function automatic int used_dims();
    if (shape_ndims == '0) return int'(NDIM_ONE);
    if (shape_ndims > NDIM_MAX) return int'(NDIM_MAX);
    return int'(shape_ndims);
  endfunction

  // extent after clamping to 1..2^COORD_BITS
  function automatic ext_t clamped_ext(int d);
    ext_t s;
    s = shape_ext[d];
    if (s == '0) return EXT_ONE;
    if (s > EXT_MAX) return EXT_MAX;
    return s;
  endfunction

  // queue the entry for a nonzero word, then step the odometer
  task automatic predict_coo(value_t v);
    coo_entry_t e;
    int nd;
    ext_t nxt;
    bit carry;
    nd = used_dims();
    if (v != '0) begin
      e.value = v;
      for (int j = 0; j < MAX_DIMS; j++) begin
        e.coord[j] = (j < nd) ? odo_coord[j] : '0;
      end
      pending_coo.push_back(e);
    end
    carry = 1'b1;
    for (int k = nd - 1; k >= 0; k--) begin
      if (carry) begin
        nxt = ext_t'(odo_coord[k]) + EXT_ONE;
        if (nxt >= clamped_ext(k)) begin
          odo_coord[k] = '0;
        end else begin
          odo_coord[k] = nxt[COORD_BITS-1:0];
          carry = 1'b0;
        end
      end
    end
  endtask

  // send one dense word; entered and left at a falling edge
  task automatic send_word(value_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_coo(v);
    @(negedge clk);
  endtask

  // register write, cfg_valid left high for a following write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NUM_DIMS:  shape_ndims = data[NDIM_BITS-1:0];
      REG_DIM0_SIZE: shape_ext[0] = data;
      REG_DIM1_SIZE: shape_ext[1] = data;
      REG_DIM2_SIZE: shape_ext[2] = data;
      REG_DIM3_SIZE: shape_ext[3] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait until every entry is out and the pipe has flushed zero words
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_coo.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // full shape write plus one write to an unmapped index
  task automatic apply_shape(ndim_t nd, ext_t s0, ext_t s1, ext_t s2, ext_t s3);
    quiesce();
    write_reg(REG_NUM_DIMS, CFG_DAT_BITS'(nd));
    write_reg(REG_DIM0_SIZE, s0);
    write_reg(REG_DIM1_SIZE, s1);
    write_reg(REG_DIM2_SIZE, s2);
    write_reg(REG_DIM3_SIZE, s3);
    write_reg(CFG_IDX_BITS'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
              CFG_DAT_BITS'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  function automatic value_t rand_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4: return value_t'(32'h8000_0000);
      5: return value_t'(32'h7fff_ffff);
      6: return value_t'(-1);
      7: return value_t'($urandom_range(15, 1));
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic ext_t rand_ext();
    case ($urandom_range(19))
      0: return '0;
      1: return EXT_MAX;
      2: return '1;
      3: return ext_t'($urandom());
      default: return ext_t'($urandom_range(6, 1));
    endcase
  endfunction

  // default shape out of reset: every word lands on coordinate zero
  task automatic test_reset_defaults();
    value_t vals [] = '{value_t'(32'h7fff_ffff), value_t'(32'h8000_0000), '0,
                        value_t'(1), value_t'(-1)};
    foreach (vals[i]) send_word(vals[i]);
  endtask

  // scalar, zero extents, too many dims and oversized extent
  task automatic test_open_cases();
    value_t scalar_vals [] = '{value_t'(-1), '0, value_t'(32'h5555_5555)};
    apply_shape('0, '0, '0, '0, '0);
    foreach (scalar_vals[i]) send_word(scalar_vals[i]);
    apply_shape('1, ext_t'(2), '0, ext_t'(3), '1);
    repeat (6) send_word(value_t'(32'haaaa_aaaa));
  endtask

  // shrink extents under a running counter so coordinates overrun and wrap
  task automatic test_midtensor_reshape();
    apply_shape(NDIM_MAX, ext_t'(3), ext_t'(3), ext_t'(3), ext_t'(3));
    for (int i = 1; i <= 4; i++) send_word(value_t'(i));
    apply_shape(NDIM_MAX, ext_t'(3), ext_t'(3), EXT_ONE, ext_t'(2));
    send_word(value_t'(32'h1234_5678));
    send_word('0);
    send_word(value_t'(-7));
    apply_shape(ndim_t'(2), ext_t'(2), ext_t'(2), ext_t'(5), ext_t'(5));
    repeat (3) send_word(value_t'(32'h0f0f_f0f0));
  endtask

  // random shapes, mostly whole small tensors with random content
  task automatic test_random_stream(int sender_pct, int receiver_pct, int target);
    int sent;
    longint total;
    int n;
    ndim_t nd;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(9))
        0: nd = '0;
        1: nd = ndim_t'($urandom_range(7, 5));
        default: nd = ndim_t'($urandom_range(4, 1));
      endcase
      apply_shape(nd, rand_ext(), rand_ext(), rand_ext(), rand_ext());
      total = 1;
      for (int d = 0; d < used_dims(); d++) total *= longint'(clamped_ext(d));
      n = (total > PHASE_MAX_WORDS) ? $urandom_range(PHASE_MAX_WORDS, 24) : int'(total);
      if (n < 8) n = n * $urandom_range(4, 2);
      if (n > target - sent) n = target - sent;
      repeat (n) send_word(rand_value());
      sent += n;
    end
  endtask

  // result side back pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result word with the oldest expected entry
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_coo.size() == 0) begin
        $display("%0t unexpected word: value %h coords %h %h %h %h", $time, out_value_out,
                 out_coord_0, out_coord_1, out_coord_2, out_coord_3);
        errors++;
      end else begin
        want = pending_coo.pop_front();
        seen_coord = '{out_coord_0, out_coord_1, out_coord_2, out_coord_3};
        if (out_value_out !== want.value) begin
          $display("%0t value mismatch: expected %h actual %h", $time, want.value,
                   out_value_out);
          errors++;
        end
        for (int j = 0; j < MAX_DIMS; j++) begin
          if (seen_coord[j] !== want.coord[j]) begin
            $display("%0t coord_%0d mismatch: expected %0d actual %0d", $time, j,
                     want.coord[j], seen_coord[j]);
            errors++;
          end
        end
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // reset, directed tests, then random under three idle mixes
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NUM_DIMS;
    cfg_data = '0;
    shape_ndims = NDIM_ONE;
    for (int d = 0; d < MAX_DIMS; d++) begin
      shape_ext[d] = EXT_ONE;
      odo_coord[d] = '0;
    end
    send_idle_pct = 23;
    recv_idle_pct = 46;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_open_cases();
    test_midtensor_reshape();
    test_random_stream(23, 46, 384);
    test_random_stream(46, 23, 384);
    test_random_stream(0, 0, 382);
    quiesce();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
